// ===== src/twi_mrb_pkg.sv =====
`default_nettype none
package twi_mrb_pkg;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [2:0] IDX_BIT_RATE = 3'd0;
    localparam logic [2:0] IDX_STATUS   = 3'd1;
    localparam logic [2:0] IDX_OWN_ADDR = 3'd2;
    localparam logic [2:0] IDX_DATA     = 3'd3;
    localparam logic [2:0] IDX_CONTROL  = 3'd4;

    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_STOP       = 3'd1;
    localparam logic [2:0] ACT_START      = 3'd2;
    localparam logic [2:0] ACT_STOP_START = 3'd3;
    localparam logic [2:0] ACT_ADDRESS    = 3'd4;
    localparam logic [2:0] ACT_SEND       = 3'd5;
    localparam logic [2:0] ACT_RECEIVE    = 3'd6;

    localparam int CR_FLAG  = 7;
    localparam int CR_START = 5;
    localparam int CR_STOP  = 4;
    localparam int CR_EN    = 2;

    localparam logic [7:0] ST_IDLE        = 8'hF8;
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RESTART     = 8'h10;
    localparam logic [7:0] ST_W_ADDR_ACK  = 8'h18;
    localparam logic [7:0] ST_W_ADDR_NACK = 8'h20;
    localparam logic [7:0] ST_W_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_W_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_R_ADDR_ACK  = 8'h40;
    localparam logic [7:0] ST_R_ADDR_NACK = 8'h48;
    localparam logic [7:0] ST_R_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_R_DATA_NACK = 8'h58;

    localparam logic [7:0] OWN_ADDR_RESET = 8'hFE;
    localparam logic [7:0] DATA_RESET     = 8'hFF;

    typedef struct packed {
        logic       req_type;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic       bus_ack;
        logic [7:0] bus_rx_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] bus_action;
        logic [7:0] bus_byte;
        logic       bus_read;
        logic       protocol_error;
    } rsp_t;

    typedef struct packed {
        logic [7:0] bit_rate;
        logic [1:0] prescaler;
        logic [4:0] status_code;
        logic [7:0] own_address;
        logic [7:0] data;
        logic [7:0] control;
        logic       owns_bus;
        logic       start_pending_address;
        logic       transmit_mode;
    } state_t;

    localparam state_t STATE_RESET = '{
        bit_rate:              8'h00,
        prescaler:             2'b00,
        status_code:           ST_IDLE[7:3],
        own_address:           OWN_ADDR_RESET,
        data:                  DATA_RESET,
        control:               8'h00,
        owns_bus:              1'b0,
        start_pending_address: 1'b0,
        transmit_mode:         1'b0
    };

endpackage
`default_nettype wire

// ===== src/twi_mrb_req_if.sv =====
`default_nettype none
interface twi_mrb_req_if
    import twi_mrb_pkg::*;
;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/twi_mrb_rsp_if.sv =====
`default_nettype none
interface twi_mrb_rsp_if
    import twi_mrb_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/twi_mrb_engine.sv =====
`default_nettype none
module twi_mrb_engine
    import twi_mrb_pkg::*;
(
    input  var state_t state,
    input  var req_t   item,
    output var state_t state_next,
    output var rsp_t   result
);

    logic       go;
    logic       done;
    logic       owns;
    logic [7:0] ctl;
    logic [7:0] status_byte;

    twi_mrb_status_view u_status_view (
        .state       (state),
        .status_byte (status_byte)
    );

    always_comb
    begin
        state_next = state;
        result     = '0;
        go         = item.write_data[CR_FLAG];
        done       = 1'b0;
        owns       = state.owns_bus;
        ctl        = {(go ? 1'b0 : state.control[CR_FLAG]), item.write_data[6:0]};
        if (item.req_type == REQ_READ)
        begin
            case (item.reg_index)
                IDX_BIT_RATE: result.read_data = state.bit_rate;
                IDX_STATUS:   result.read_data = status_byte;
                IDX_OWN_ADDR: result.read_data = state.own_address;
                IDX_DATA:     result.read_data = state.data;
                IDX_CONTROL:  result.read_data = state.control;
                default:      result.read_data = 8'h00;
            endcase
        end
        else
        begin
            case (item.reg_index)
                IDX_BIT_RATE: state_next.bit_rate = item.write_data;
                IDX_STATUS:   state_next.prescaler = item.write_data[1:0];
                IDX_OWN_ADDR: state_next.own_address = item.write_data;
                IDX_DATA:     state_next.data = item.write_data;
                IDX_CONTROL:
                begin
                    if (!ctl[CR_EN])
                    begin
                        owns = 1'b0;
                    end
                    else if (go)
                    begin
                        ctl[CR_FLAG] = 1'b1;
                        if (ctl[CR_STOP])
                        begin
                            result.bus_action = ACT_STOP;
                            state_next.status_code = ST_IDLE[7:3];
                            ctl[CR_STOP] = 1'b0;
                            owns = 1'b0;
                            state_next.start_pending_address = 1'b0;
                            done = !ctl[CR_START];
                        end
                        if (!done && ctl[CR_START])
                        begin
                            result.bus_action = (result.bus_action == ACT_STOP) ?
                                                ACT_STOP_START : ACT_START;
                            state_next.status_code = owns ? ST_RESTART[7:3] : ST_START[7:3];
                            owns = 1'b1;
                            state_next.start_pending_address = 1'b1;
                            done = 1'b1;
                        end
                        if (!done)
                        begin
                            if (!owns)
                            begin
                                result.protocol_error = 1'b1;
                            end
                            else if (state.start_pending_address)
                            begin
                                state_next.transmit_mode = !state.data[0];
                                result.bus_action = ACT_ADDRESS;
                                result.bus_byte = {1'b0, state.data[7:1]};
                                result.bus_read = state.data[0];
                                if (!state.data[0])
                                begin
                                    state_next.status_code = item.bus_ack ?
                                        ST_W_ADDR_ACK[7:3] : ST_W_ADDR_NACK[7:3];
                                end
                                else
                                begin
                                    state_next.status_code = item.bus_ack ?
                                        ST_R_ADDR_ACK[7:3] : ST_R_ADDR_NACK[7:3];
                                end
                                state_next.start_pending_address = 1'b0;
                            end
                            else if (state.transmit_mode)
                            begin
                                result.bus_action = ACT_SEND;
                                result.bus_byte = state.data;
                                state_next.status_code = item.bus_ack ?
                                    ST_W_DATA_ACK[7:3] : ST_W_DATA_NACK[7:3];
                            end
                            else
                            begin
                                result.bus_action = ACT_RECEIVE;
                                state_next.data = item.bus_rx_data;
                                result.bus_byte = item.bus_rx_data;
                                state_next.status_code = item.bus_ack ?
                                    ST_R_DATA_ACK[7:3] : ST_R_DATA_NACK[7:3];
                            end
                        end
                    end
                    state_next.owns_bus = owns;
                    state_next.control  = ctl;
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/twi_mrb_engine_unused_guard.sv =====
`default_nettype none
module twi_mrb_status_view
    import twi_mrb_pkg::*;
(
    input  var state_t     state,
    output var logic [7:0] status_byte
);

    assign status_byte = {state.status_code, 1'b0, state.prescaler};

endmodule
`default_nettype wire

// ===== src/twi_master_register_block_core.sv =====
`default_nettype none
// Channel | Dir | Payload
// --------+-----+----------------------------------------------------------
// req     | in  | req_type, reg_index, write_data, bus_ack, bus_rx_data
// rsp     | out | read_data, bus_action, bus_byte, bus_read, protocol_error
//
// One transfer can be accepted on every cycle while results are taken; each request
// passes through the input register and then the result register. Register state is
// updated as a request leaves the input register, so the next request always sees it.
// Reset clears the valid flags and brings the register state to its documented values;
// the input and result data registers are not reset. When the result is not taken, the
// result register holds, and req.ready falls once the input register is also full.
module twi_master_register_block_core
    import twi_mrb_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    twi_mrb_req_if.sink    req,
    twi_mrb_rsp_if.source  rsp
);

    logic   in_valid_reg;
    req_t   in_data_reg;
    logic   out_valid_reg;
    rsp_t   out_data_reg;
    state_t state_reg;
    state_t state_next;
    rsp_t   result;
    logic   advance;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    twi_mrb_engine u_engine (
        .state      (state_reg),
        .item       (in_data_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_valid_reg && advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_data_reg <= req.data;
        end
        if (in_valid_reg && advance)
        begin
            out_data_reg <= result;
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_twi_master_register_block_core.sv =====
`timescale 1ns / 1ps

module tb_twi_master_register_block_core;
    import twi_mrb_pkg::*;

    localparam int          RANDOM_ITEMS  = 600;
    localparam int          LONG_HOLD     = 120;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES  = 8;
    localparam logic [2:0]  IDX_SPARE_LO  = 3'd5;
    localparam logic [2:0]  IDX_SPARE_HI  = 3'd7;
    localparam rsp_t        IDLE_RSP      = '0;

    typedef struct packed {
        req_t stim;
        logic pinned;
        rsp_t want;
    } access_row_t;

    logic clk = 1'b0;
    logic rst_n;

    twi_mrb_req_if req_ch ();
    twi_mrb_rsp_if rsp_ch ();

    twi_master_register_block_core DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    state_t      reg_shadow;
    rsp_t        awaited_rsp[$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned stall_cycles = 0;
    logic        long_hold_req = 1'b0;
    rsp_t        arrived_want;

    // Rows with pinned set carry a result that follows directly from the register map.
    access_row_t directed_rows [26] = '{
        '{ {REQ_READ,  IDX_BIT_RATE, 8'h00, 1'b0, 8'h00}, 1'b1,
           {8'h00, ACT_NONE, 8'h00, 1'b0, 1'b0} },
        '{ {REQ_READ,  IDX_STATUS,   8'hFF, 1'b1, 8'hFF}, 1'b1,
           {8'hF8, ACT_NONE, 8'h00, 1'b0, 1'b0} },
        '{ {REQ_READ,  IDX_OWN_ADDR, 8'h00, 1'b0, 8'h00}, 1'b1,
           {8'hFE, ACT_NONE, 8'h00, 1'b0, 1'b0} },
        '{ {REQ_READ,  IDX_DATA,     8'h00, 1'b0, 8'h00}, 1'b1,
           {8'hFF, ACT_NONE, 8'h00, 1'b0, 1'b0} },
        '{ {REQ_READ,  IDX_CONTROL,  8'h00, 1'b0, 8'h00}, 1'b1,
           {8'h00, ACT_NONE, 8'h00, 1'b0, 1'b0} },
        '{ {REQ_READ,  IDX_SPARE_HI, 8'h00, 1'b0, 8'h00}, 1'b1, IDLE_RSP },
        '{ {REQ_WRITE, IDX_SPARE_LO, 8'hFF, 1'b1, 8'hFF}, 1'b1, IDLE_RSP },
        '{ {REQ_WRITE, IDX_BIT_RATE, 8'hFF, 1'b0, 8'h00}, 1'b1, IDLE_RSP },
        '{ {REQ_WRITE, IDX_STATUS,   8'hFF, 1'b0, 8'h00}, 1'b1, IDLE_RSP },
        '{ {REQ_READ,  IDX_STATUS,   8'h00, 1'b0, 8'h00}, 1'b1,
           {8'hFB, ACT_NONE, 8'h00, 1'b0, 1'b0} },
        '{ {REQ_WRITE, IDX_OWN_ADDR, 8'h00, 1'b0, 8'h00}, 1'b1, IDLE_RSP },
        '{ {REQ_READ,  IDX_OWN_ADDR, 8'h00, 1'b0, 8'h00}, 1'b1,
           {8'h00, ACT_NONE, 8'h00, 1'b0, 1'b0} },
        '{ {REQ_WRITE, IDX_CONTROL,  8'h80, 1'b1, 8'h00}, 1'b1, IDLE_RSP },
        '{ {REQ_WRITE, IDX_CONTROL,  8'h84, 1'b1, 8'h00}, 1'b1,
           {8'h00, ACT_NONE, 8'h00, 1'b0, 1'b1} },
        '{ {REQ_READ,  IDX_CONTROL,  8'h00, 1'b0, 8'h00}, 1'b1,
           {8'h84, ACT_NONE, 8'h00, 1'b0, 1'b0} },
        '{ {REQ_WRITE, IDX_DATA,     8'hA5, 1'b0, 8'h00}, 1'b1, IDLE_RSP },
        '{ {REQ_WRITE, IDX_CONTROL,  8'hA4, 1'b0, 8'h00}, 1'b1,
           {8'h00, ACT_START, 8'h00, 1'b0, 1'b0} },
        '{ {REQ_WRITE, IDX_CONTROL,  8'h84, 1'b1, 8'h00}, 1'b1,
           {8'h00, ACT_ADDRESS, 8'h52, 1'b1, 1'b0} },
        '{ {REQ_READ,  IDX_STATUS,   8'h00, 1'b0, 8'h00}, 1'b1,
           {8'h43, ACT_NONE, 8'h00, 1'b0, 1'b0} },
        '{ {REQ_WRITE, IDX_CONTROL,  8'h84, 1'b0, 8'hFF}, 1'b1,
           {8'h00, ACT_RECEIVE, 8'hFF, 1'b0, 1'b0} },
        '{ {REQ_WRITE, IDX_CONTROL,  8'h04, 1'b1, 8'h3C}, 1'b0, IDLE_RSP },
        '{ {REQ_READ,  IDX_CONTROL,  8'h00, 1'b0, 8'h00}, 1'b1,
           {8'h84, ACT_NONE, 8'h00, 1'b0, 1'b0} },
        '{ {REQ_WRITE, IDX_CONTROL,  8'hB4, 1'b0, 8'h00}, 1'b1,
           {8'h00, ACT_STOP_START, 8'h00, 1'b0, 1'b0} },
        '{ {REQ_WRITE, IDX_DATA,     8'h00, 1'b1, 8'hC3}, 1'b0, IDLE_RSP },
        '{ {REQ_WRITE, IDX_CONTROL,  8'hC4, 1'b0, 8'h00}, 1'b1,
           {8'h00, ACT_ADDRESS, 8'h00, 1'b0, 1'b0} },
        '{ {REQ_WRITE, IDX_CONTROL,  8'h94, 1'b1, 8'h00}, 1'b1,
           {8'h00, ACT_STOP, 8'h00, 1'b0, 1'b0} }
    };

    function automatic logic [4:0] status_field(input logic [7:0] code);
        return code[7:3];
    endfunction

    function automatic rsp_t predict_access(input req_t r);
        rsp_t       res;
        logic [7:0] ctl;
        logic       done;
        res  = '0;
        done = 1'b0;
        if (r.req_type == REQ_READ)
        begin
            case (r.reg_index)
                IDX_BIT_RATE: res.read_data = reg_shadow.bit_rate;
                IDX_STATUS:
                    res.read_data = {reg_shadow.status_code, 1'b0, reg_shadow.prescaler};
                IDX_OWN_ADDR: res.read_data = reg_shadow.own_address;
                IDX_DATA:     res.read_data = reg_shadow.data;
                IDX_CONTROL:  res.read_data = reg_shadow.control;
                default:      res.read_data = 8'h00;
            endcase
        end
        else
        begin
            case (r.reg_index)
                IDX_BIT_RATE: reg_shadow.bit_rate = r.write_data;
                IDX_STATUS:   reg_shadow.prescaler = r.write_data[1:0];
                IDX_OWN_ADDR: reg_shadow.own_address = r.write_data;
                IDX_DATA:     reg_shadow.data = r.write_data;
                IDX_CONTROL:
                begin
                    ctl = r.write_data;
                    ctl[CR_FLAG] = r.write_data[CR_FLAG] ? 1'b0 : reg_shadow.control[CR_FLAG];
                    if (!ctl[CR_EN])
                    begin
                        reg_shadow.owns_bus = 1'b0;
                    end
                    else if (r.write_data[CR_FLAG])
                    begin
                        ctl[CR_FLAG] = 1'b1;
                        if (ctl[CR_STOP])
                        begin
                            res.bus_action = ACT_STOP;
                            reg_shadow.status_code = status_field(ST_IDLE);
                            ctl[CR_STOP] = 1'b0;
                            reg_shadow.owns_bus = 1'b0;
                            reg_shadow.start_pending_address = 1'b0;
                            done = !ctl[CR_START];
                        end
                        if (!done && ctl[CR_START])
                        begin
                            res.bus_action = (res.bus_action == ACT_STOP) ? ACT_STOP_START
                                                                          : ACT_START;
                            reg_shadow.status_code = status_field(
                                reg_shadow.owns_bus ? ST_RESTART : ST_START);
                            reg_shadow.owns_bus = 1'b1;
                            reg_shadow.start_pending_address = 1'b1;
                            done = 1'b1;
                        end
                        if (!done)
                        begin
                            if (!reg_shadow.owns_bus)
                            begin
                                res.protocol_error = 1'b1;
                            end
                            else if (reg_shadow.start_pending_address)
                            begin
                                reg_shadow.transmit_mode = !reg_shadow.data[0];
                                res.bus_action = ACT_ADDRESS;
                                res.bus_byte = {1'b0, reg_shadow.data[7:1]};
                                res.bus_read = reg_shadow.data[0];
                                if (reg_shadow.transmit_mode)
                                    reg_shadow.status_code = status_field(
                                        r.bus_ack ? ST_W_ADDR_ACK : ST_W_ADDR_NACK);
                                else
                                    reg_shadow.status_code = status_field(
                                        r.bus_ack ? ST_R_ADDR_ACK : ST_R_ADDR_NACK);
                                reg_shadow.start_pending_address = 1'b0;
                            end
                            else if (reg_shadow.transmit_mode)
                            begin
                                res.bus_action = ACT_SEND;
                                res.bus_byte = reg_shadow.data;
                                reg_shadow.status_code = status_field(
                                    r.bus_ack ? ST_W_DATA_ACK : ST_W_DATA_NACK);
                            end
                            else
                            begin
                                res.bus_action = ACT_RECEIVE;
                                reg_shadow.data = r.bus_rx_data;
                                res.bus_byte = r.bus_rx_data;
                                reg_shadow.status_code = status_field(
                                    r.bus_ack ? ST_R_DATA_ACK : ST_R_DATA_NACK);
                            end
                        end
                    end
                    reg_shadow.control = ctl;
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    task automatic send_access(input req_t item, input logic pinned, input rsp_t want);
        rsp_t        predicted;
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = predict_access(item);
        awaited_rsp.push_back(pinned ? want : predicted);
        items_sent++;
    endtask

    task automatic issue(input logic kind, input logic [2:0] idx, input logic [7:0] value);
        send_access({kind, idx, value, 1'($urandom_range(0, 1)), 8'($urandom)}, 1'b0, IDLE_RSP);
    endtask

    function automatic logic [7:0] control_word(input logic go, input logic start_bit,
                                                input logic stop_bit, input logic enable);
        logic [7:0] w;
        w = 8'($urandom);
        w[CR_FLAG]  = go;
        w[CR_START] = start_bit;
        w[CR_STOP]  = stop_bit;
        w[CR_EN]    = enable;
        return w;
    endfunction

    // One master transaction: start, address, up to six data bytes, then stop, stop plus start,
    // or nothing so that the next transaction begins with a repeated start.
    task automatic bus_transaction();
        int unsigned byte_count;
        logic        read_dir;
        byte_count = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
        read_dir   = 1'($urandom_range(0, 1));
        issue(REQ_WRITE, IDX_DATA, {7'($urandom), read_dir});
        issue(REQ_WRITE, IDX_CONTROL, control_word(1'b1, 1'b1, 1'b0, 1'b1));
        issue(REQ_WRITE, IDX_CONTROL, control_word(1'b1, 1'b0, 1'b0, 1'b1));
        repeat (byte_count)
        begin
            if (!read_dir)
                issue(REQ_WRITE, IDX_DATA, 8'($urandom));
            issue(REQ_WRITE, IDX_CONTROL, control_word(1'b1, 1'b0, 1'b0, 1'b1));
            if ($urandom_range(0, 5) == 0)
                issue(REQ_READ, 3'($urandom_range(0, 7)), 8'($urandom));
        end
        case ($urandom_range(0, 3))
            0: issue(REQ_WRITE, IDX_CONTROL, control_word(1'b1, 1'b1, 1'b1, 1'b1));
            1: ;
            default: issue(REQ_WRITE, IDX_CONTROL, control_word(1'b1, 1'b0, 1'b1, 1'b1));
        endcase
    endtask

    initial
    begin : stimulus
        logic second_hold_done;
        second_hold_done = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        reg_shadow.bit_rate              = 8'h00;
        reg_shadow.prescaler             = 2'b00;
        reg_shadow.status_code           = status_field(ST_IDLE);
        reg_shadow.own_address           = OWN_ADDR_RESET;
        reg_shadow.data                  = DATA_RESET;
        reg_shadow.control               = 8'h00;
        reg_shadow.owns_bus              = 1'b0;
        reg_shadow.start_pending_address = 1'b0;
        reg_shadow.transmit_mode         = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_access(directed_rows[i].stim, directed_rows[i].pinned, directed_rows[i].want);

        long_hold_req = 1'b1;
        while (items_sent < RANDOM_ITEMS + 26)
        begin
            if (!second_hold_done && items_sent > 350)
            begin
                long_hold_req    = 1'b1;
                second_hold_done = 1'b1;
            end
            if ($urandom_range(0, 3) != 0)
                bus_transaction();
            else
                repeat ($urandom_range(1, 4))
                    issue(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 8'($urandom));
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_twi_master_register_block_core: PASS");
        else
            $display("tb_twi_master_register_block_core: FAIL");
        $finish;
    end

    initial
    begin : receiver
        int unsigned tick;
        int unsigned held;
        logic [7:0]  stall_mask;
        tick       = 0;
        stall_mask = 8'h00;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                rsp_ch.ready <= 1'b0;
                for (held = 1; held < LONG_HOLD; held++)
                    @(negedge clk);
                long_hold_req = 1'b0;
            end
            else
            begin
                if (tick % 48 == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: stall_mask = 8'h00;
                        1: stall_mask = 8'($urandom) & 8'hEF;
                        2: stall_mask = 8'hAA;
                        default: stall_mask = 8'h0F;
                    endcase
                end
                rsp_ch.ready <= !stall_mask[tick % 8];
                tick++;
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_rsp.size() == 0)
            begin
                $display("%0t: transfer with no expected result, expected none, actual %0h",
                         $time, rsp_ch.data);
                mismatch_count++;
            end
            else
            begin
                arrived_want = awaited_rsp.pop_front();
                check_field("read_data", arrived_want.read_data, rsp_ch.data.read_data);
                check_field("bus_action", 8'(arrived_want.bus_action),
                            8'(rsp_ch.data.bus_action));
                check_field("bus_byte", arrived_want.bus_byte, rsp_ch.data.bus_byte);
                check_field("bus_read", 8'(arrived_want.bus_read), 8'(rsp_ch.data.bus_read));
                check_field("protocol_error", 8'(arrived_want.protocol_error),
                            8'(rsp_ch.data.protocol_error));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("tb_twi_master_register_block_core: FAIL");
            $finish;
        end
    end

endmodule
